// ===== rtl/bffa_pkg.sv =====
// Shared types and constants of the first-fit bitmap allocator.
// Holds status codes, field widths and the controller-to-datapath buses.
// No dependencies.
package bffa_pkg;

  // field widths fixed by the interface
  localparam int REQ_W    = 16;
  localparam int OFS_IN_W = 16;
  localparam int POOL_W   = 16;
  localparam int OFS_W    = 15;
  localparam int STATUS_W = 2;

  // map row width, blocks examined per scan cycle
  localparam int ROW_W = 8;

  // defaults for the top-level parameters
  localparam int DEF_NUM_BLOCKS  = 1024;
  localparam int DEF_BLOCK_BYTES = 32;

  localparam logic [POOL_W-1:0] POOL_RESET = 16'd32768;

  // request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // response codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_RUN   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load_req;
    logic    clear_step;
    logic    div_step;
    logic    scan_start;
    logic    scan_step;
    logic    mark_start;
    logic    mark_step;
    logic    free_rd;
    logic    free_wr;
    logic    res_load;
    status_e res_status;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic mode_free;
    logic size_bad;
    logic free_bad;
    logic scan_found;
    logic scan_fail;
    logic mark_last;
  } dp_sts_t;

endpackage

// ===== rtl/bitmap_first_fit_allocator.sv =====
// First-fit block allocator over a one-bit-per-block occupancy map.
// Top level: joins bffa_ctrl and bffa_dpath; depends on bffa_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per
//   transaction: mode_i 0 allocates request_bytes_i, mode_i 1 frees the block
//   at release_offset_i. Output channel (out_valid_o / out_stall_i) returns
//   exactly one status_o and granted_offset_o per request. pool_bytes_i is
//   written when cfg_we_i is high and must only change while the block is
//   idle.
// Sequencing:
//   one request at a time. An allocate decodes the request, scans the map one
//   8-block row per step (up to ceil(NUM_BLOCKS/8) rows), then marks each row
//   covered by the granted run; the scan rate is set by the single read port
//   of the map memory. A free does an offset division, a range check
//   and a read-modify-write of one map row. Bad sizes skip to the response.
// Reset:
//   the map memory is cleared one row per cycle, all ceil(NUM_BLOCKS/8) rows
//   (128 at the default size), with in_stall_o high throughout.
// Stall:
//   a finished result waits in the output register; the next request is
//   taken meanwhile, and its result waits until the register is emptied.
module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [POOL_W-1:0]   pool_bytes_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [OFS_IN_W-1:0] release_offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [OFS_W-1:0]    granted_offset_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing and handshakes
  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // map memory, scan and result datapath
  bffa_dpath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .pool_bytes_i     (pool_bytes_i),
    .mode_i           (mode_i),
    .request_bytes_i  (request_bytes_i),
    .release_offset_i (release_offset_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o)
  );

endmodule

// ===== rtl/bffa_dpath.sv =====
// Datapath of the first-fit bitmap allocator: occupancy map memory, scan,
// run marking, offset divider for frees and the result register.
// Depends on bffa_pkg.
module bffa_dpath import bffa_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [POOL_W-1:0]   pool_bytes_i,
  input  logic                mode_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [OFS_IN_W-1:0] release_offset_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OFS_W-1:0]    granted_offset_o
);

  localparam int ROWS    = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW  = $clog2((ROWS > 1) ? ROWS : 2);
  localparam int ROW_LW  = $clog2(ROW_W);
  localparam int IDX_W   = ROW_AW + ROW_LW;
  localparam int RUN_W   = $clog2((2 ** REQ_W) + BLOCK_BYTES);
  localparam int BYTE_W0 = $clog2((ROWS + 1) * ROW_W * BLOCK_BYTES) + 1;
  localparam int BYTE_W  = (BYTE_W0 > RUN_W + 1) ? BYTE_W0 : RUN_W + 1;

  // reciprocal of the block size, exact for every 16-bit offset
  localparam int          DIV_SH = OFS_IN_W + $clog2(BLOCK_BYTES);
  localparam int          PROD_W = 2 * OFS_IN_W + 1;
  localparam int          BACK_W = OFS_IN_W + $clog2(BLOCK_BYTES + 1);
  localparam logic [63:0] RECIP  =
      ((64'd1 << DIV_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  // configuration register
  logic [POOL_W-1:0] pool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= POOL_RESET;
    end else if (cfg_we_i) begin
      pool_q <= pool_bytes_i;
    end
  end

  // request registers and offset division by reciprocal multiplication
  logic                mode_q;
  logic [REQ_W-1:0]    size_q;
  logic [OFS_IN_W-1:0] ofs_q;
  logic [OFS_IN_W-1:0] quot_q;
  logic [PROD_W-1:0]   recip_prod;
  logic [BACK_W-1:0]   back;

  assign recip_prod = PROD_W'(ofs_q) * PROD_W'(RECIP);
  assign back       = BACK_W'(quot_q) * BACK_W'(BLOCK_BYTES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= mode_i;
      size_q <= request_bytes_i;
      ofs_q  <= release_offset_i;
    end else if (cmd_i.div_step) begin
      quot_q <= OFS_IN_W'(recip_prod >> DIV_SH);
    end
  end

  logic [ROW_AW-1:0] free_row;
  logic [ROW_LW-1:0] free_bit;

  assign free_row = quot_q[IDX_W-1:ROW_LW];
  assign free_bit = quot_q[ROW_LW-1:0];

  // row pointer shared by clearing, scanning and marking
  logic [ROW_AW-1:0] row_q;
  logic [IDX_W-1:0]  start_q, end_q;
  logic [RUN_W-1:0]  run_q;
  logic [BYTE_W-1:0] base_q;
  logic [OFS_W-1:0]  granted_q;

  // map memory
  logic [ROW_W-1:0]  mem_q [ROWS];
  logic [ROW_W-1:0]  rd_data_q;
  logic [ROW_AW-1:0] rd_addr, wr_addr;
  logic [ROW_W-1:0]  wr_data, mark_mask, free_mask;
  logic              wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // bits of the current row that fall inside the run being marked, and the freed bit
  always_comb begin
    logic [IDX_W-1:0] idx;
    mark_mask = '0;
    free_mask = '0;
    for (int k = 0; k < ROW_W; k++) begin
      idx = {row_q, ROW_LW'(k)};
      mark_mask[k] = (idx >= start_q) && (idx <= end_q);
      free_mask[k] = (free_bit == ROW_LW'(k));
    end
  end

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = '0;
    rd_addr = row_q;
    if (cmd_i.clear_step) begin
      wr_en = 1'b1;
    end
    if (cmd_i.mark_step) begin
      wr_en   = 1'b1;
      wr_data = rd_data_q | mark_mask;
      rd_addr = row_q + ROW_AW'(1);
    end
    if (cmd_i.free_wr) begin
      wr_en   = 1'b1;
      wr_addr = free_row;
      wr_data = rd_data_q & ~free_mask;
    end
    if (cmd_i.scan_start) begin
      rd_addr = '0;
    end
    if (cmd_i.scan_step) begin
      rd_addr = row_q + ROW_AW'(1);
    end
    if (cmd_i.mark_start) begin
      rd_addr = start_q[IDX_W-1:ROW_LW];
    end
    if (cmd_i.free_rd) begin
      rd_addr = free_row;
    end
  end

  // first-fit scan over one row, run length kept in bytes
  logic [BYTE_W-1:0] byte_end [ROW_W];
  logic [ROW_W-1:0]  in_use;
  logic [RUN_W-1:0]  run_d;
  logic [IDX_W-1:0]  start_d, end_d;
  logic [BYTE_W-1:0] end_byte;
  logic              found;

  always_comb begin
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < ROW_W; k++) begin
      idx = {row_q, ROW_LW'(k)};
      byte_end[k] = base_q + BYTE_W'((k + 1) * BLOCK_BYTES);
      in_use[k]   = (32'(idx) < 32'(NUM_BLOCKS)) && (byte_end[k] <= BYTE_W'(pool_q));
    end
  end

  always_comb begin
    logic [IDX_W-1:0] idx;
    run_d    = run_q;
    start_d  = start_q;
    end_d    = end_q;
    end_byte = '0;
    found    = 1'b0;
    for (int k = 0; k < ROW_W; k++) begin
      idx = {row_q, ROW_LW'(k)};
      if (!found && in_use[k]) begin
        if (!rd_data_q[k]) begin
          if (run_d == '0) begin
            start_d = idx;
          end
          run_d = run_d + RUN_W'(BLOCK_BYTES);
          if (run_d >= RUN_W'(size_q)) begin
            found    = 1'b1;
            end_d    = idx;
            end_byte = byte_end[k];
          end
        end else begin
          run_d = '0;
        end
      end
    end
  end

  logic [BYTE_W-1:0] grant_bytes;
  assign grant_bytes = end_byte - BYTE_W'(run_d);

  // scan and row pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (cmd_i.scan_start) begin
      row_q <= '0;
    end else if (cmd_i.mark_start) begin
      row_q <= start_q[IDX_W-1:ROW_LW];
    end else if (cmd_i.clear_step || cmd_i.scan_step || cmd_i.mark_step) begin
      row_q <= row_q + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      granted_q <= '0;
    end
    if (cmd_i.scan_start) begin
      run_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.scan_step) begin
      run_q   <= run_d;
      start_q <= start_d;
      base_q  <= base_q + BYTE_W'(ROW_W * BLOCK_BYTES);
      if (found) begin
        end_q     <= end_d;
        granted_q <= grant_bytes[OFS_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_o         <= cmd_i.res_status;
      granted_offset_o <= granted_q;
    end
  end

  // status back to the controller
  assign sts_o.clear_last = (row_q == ROW_AW'(ROWS - 1));
  assign sts_o.mode_free  = (mode_q == MODE_FREE);
  assign sts_o.size_bad   = (size_q == '0) || (size_q > pool_q);
  assign sts_o.free_bad   = (back != BACK_W'(ofs_q)) || (32'(quot_q) >= 32'(NUM_BLOCKS));
  assign sts_o.scan_found = found;
  assign sts_o.scan_fail  = !found &&
                            (!in_use[ROW_W-1] || (row_q == ROW_AW'(ROWS - 1)));
  assign sts_o.mark_last  = (row_q == end_q[IDX_W-1:ROW_LW]);

endmodule

// ===== rtl/bffa_ctrl.sv =====
// Controller of the first-fit bitmap allocator: sequences map clearing,
// allocate scans, run marking, frees and the result handshake.
// Depends on bffa_pkg.
module bffa_ctrl import bffa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b0000_0000_0001,
    S_IDLE       = 12'b0000_0000_0010,
    S_DISPATCH   = 12'b0000_0000_0100,
    S_DIV        = 12'b0000_0000_1000,
    S_FREE_CHK   = 12'b0000_0001_0000,
    S_FREE_RD    = 12'b0000_0010_0000,
    S_FREE_WR    = 12'b0000_0100_0000,
    S_SCAN_START = 12'b0000_1000_0000,
    S_SCAN       = 12'b0001_0000_0000,
    S_MARK_START = 12'b0010_0000_0000,
    S_MARK       = 12'b0100_0000_0000,
    S_RESP       = 12'b1000_0000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    out_valid_q, out_valid_d;
  logic    can_load;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d          = state_q;
    code_d           = code_q;
    cmd_o            = '0;
    cmd_o.res_status = code_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.mode_free) begin
          state_d = S_DIV;
        end else if (sts_i.size_bad) begin
          code_d  = ST_BAD_SIZE;
          state_d = S_RESP;
        end else begin
          state_d = S_SCAN_START;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (sts_i.free_bad) begin
          code_d  = ST_BAD_FREE;
          state_d = S_RESP;
        end else begin
          state_d = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
        code_d        = ST_OK;
        state_d       = S_RESP;
      end
      S_SCAN_START: begin
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_found) begin
          state_d = S_MARK_START;
        end else if (sts_i.scan_fail) begin
          code_d  = ST_NO_RUN;
          state_d = S_RESP;
        end
      end
      S_MARK_START: begin
        cmd_o.mark_start = 1'b1;
        state_d          = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_last) begin
          code_d  = ST_OK;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (can_load) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the first-fit bitmap block allocator.
// A scoreboard class holds a shadow occupancy map and predicts every response.
// Depends on rtl/bffa_pkg.sv and rtl/bitmap_first_fit_allocator.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;

  localparam int NUM_BLOCKS  = DEF_NUM_BLOCKS;
  localparam int BLOCK_BYTES = DEF_BLOCK_BYTES;
  localparam int CLK_PERIOD  = 10;
  // the long receiver hold-off (LONG_HOLD) outlasts the longest allocate
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  // expected response of one request
  typedef struct {
    status_e            status;
    logic [OFS_W-1:0]   offset;
  } grant_t;

  // shadow occupancy map, pool setting and queue of expected responses
  class bitmap_tracker;
    bit          busy [NUM_BLOCKS];
    int unsigned pool;
    grant_t      pending_grants [$];
    int unsigned failures;

    function new();
      foreach (busy[i]) busy[i] = 1'b0;
      pool     = POOL_RESET;
      failures = 0;
    endfunction

    function void set_pool(logic [POOL_W-1:0] bytes);
      pool = bytes;
    endfunction

    function int unsigned pending();
      return pending_grants.size();
    endfunction

    // predict the response of an accepted request and update the map
    function void book_request(logic m, logic [REQ_W-1:0] rq, logic [OFS_IN_W-1:0] ofs);
      grant_t      g;
      int unsigned need, live, run, first, idx;
      g.status = ST_OK;
      g.offset = '0;
      if (m == MODE_ALLOC) begin
        if (rq == 0 || rq > pool) begin
          g.status = ST_BAD_SIZE;
        end else begin
          need = (rq + BLOCK_BYTES - 1) / BLOCK_BYTES;
          live = pool / BLOCK_BYTES;
          if (live > NUM_BLOCKS) live = NUM_BLOCKS;
          g.status = ST_NO_RUN;
          run = 0;
          // first fit: lowest run of free blocks that is long enough
          for (int i = 0; i < live; i++) begin
            if (busy[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == need) begin
                first = i + 1 - need;
                for (int j = first; j <= i; j++) busy[j] = 1'b1;
                g.status = ST_OK;
                g.offset = OFS_W'(first * BLOCK_BYTES);
                break;
              end
            end
          end
        end
      end else begin
        // single-block release, any block inside the map
        idx = ofs / BLOCK_BYTES;
        if ((ofs % BLOCK_BYTES) != 0 || idx >= NUM_BLOCKS) begin
          g.status = ST_BAD_FREE;
        end else begin
          busy[idx] = 1'b0;
        end
      end
      pending_grants.push_back(g);
    endfunction

    // compare one response against the oldest expectation
    function void check_grant(logic [STATUS_W-1:0] st, logic [OFS_W-1:0] ofs);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $error("response with nothing outstanding: status %0d granted_offset %0d", st, ofs);
        failures++;
        return;
      end
      want = pending_grants.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        failures++;
      end
      if (ofs !== want.offset) begin
        $error("granted_offset: expected %0d, actual %0d", want.offset, ofs);
        failures++;
      end
    endfunction
  endclass

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [POOL_W-1:0]   pool_bytes_i     = POOL_RESET;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic                mode_i           = MODE_ALLOC;
  logic [REQ_W-1:0]    request_bytes_i  = '0;
  logic [OFS_IN_W-1:0] release_offset_i = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [OFS_W-1:0]    granted_offset_o;

  bitmap_tracker tracker;
  bit            no_idle     = 1'b0;
  int unsigned   grants_seen = 0;
  int unsigned   idle_cycles = 0;

  bitmap_first_fit_allocator #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .pool_bytes_i     (pool_bytes_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .request_bytes_i  (request_bytes_i),
    .release_offset_i (release_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // response monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_grant(status_o, granted_offset_o);
        grants_seen <= grants_seen + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to back up the block
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && grants_seen >= 150) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(9, 0) < 3) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(7, 1)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
      end
    end
  end

  // offer one request and hold it until the transaction completes
  task automatic issue(input logic m, input logic [REQ_W-1:0] rq,
                       input logic [OFS_IN_W-1:0] ofs);
    mode_i           <= m;
    request_bytes_i  <= rq;
    release_offset_i <= ofs;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.book_request(m, rq, ofs);
    if (!no_idle && $urandom_range(9, 0) < 3) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every outstanding response
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_pool(input logic [POOL_W-1:0] bytes);
    settle();
    cfg_we_i     <= 1'b1;
    pool_bytes_i <= bytes;
    @(posedge clk_i);
    tracker.set_pool(bytes);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly small allocations and frees of live blocks, some out-of-range noise
  task automatic random_request(input int unsigned pool);
    int unsigned         live, pick;
    logic                m;
    logic [REQ_W-1:0]    rq;
    logic [OFS_IN_W-1:0] ofs;
    live = pool / BLOCK_BYTES;
    if (live > NUM_BLOCKS) live = NUM_BLOCKS;
    m    = ($urandom_range(99, 0) < 45) ? MODE_FREE : MODE_ALLOC;
    rq   = REQ_W'($urandom());
    ofs  = OFS_IN_W'($urandom());
    pick = $urandom_range(99, 0);
    if (m == MODE_ALLOC) begin
      if (pick < 5) begin
        rq = '0;
      end else if (pick < 13 && pool > 0) begin
        rq = REQ_W'($urandom_range(pool, 1));
      end else if (pick >= 18) begin
        rq = REQ_W'($urandom_range(256, 1));
      end
    end else begin
      if (pick < 70 && live > 0) begin
        ofs = OFS_IN_W'($urandom_range(live - 1, 0) * BLOCK_BYTES);
      end else if (pick < 85) begin
        ofs = OFS_IN_W'($urandom_range(2 * NUM_BLOCKS - 1, 0) * BLOCK_BYTES);
      end
    end
    issue(m, rq, ofs);
  endtask

  task automatic random_phase(input logic [POOL_W-1:0] bytes, input int unsigned count);
    write_pool(bytes);
    repeat (count) random_request(bytes);
  endtask

  // main sequence
  initial begin
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // size checks, first fit, partial release and bad frees at the reset pool
    issue(MODE_ALLOC, 16'd0,     16'hFFFF);
    issue(MODE_ALLOC, 16'd32769, 16'd0);
    issue(MODE_ALLOC, 16'hFFFF,  16'd0);
    issue(MODE_ALLOC, 16'd1,     16'd0);
    issue(MODE_ALLOC, 16'd32,    16'd0);
    issue(MODE_ALLOC, 16'd33,    16'd0);
    issue(MODE_FREE,  16'hFFFF,  16'd32);
    issue(MODE_ALLOC, 16'd32,    16'd0);
    issue(MODE_FREE,  16'd0,     16'd64);
    issue(MODE_FREE,  16'd0,     16'd64);
    issue(MODE_ALLOC, 16'd64,    16'd0);
    issue(MODE_FREE,  16'd0,     16'd65);
    issue(MODE_FREE,  16'd0,     16'hFFFF);
    issue(MODE_FREE,  16'd0,     16'd32768);
    issue(MODE_FREE,  16'd0,     16'd65504);
    issue(MODE_ALLOC, 16'd32768, 16'd0);

    // tiny pool: fill it, then free a block beyond the pool but inside the map
    write_pool(16'd128);
    issue(MODE_ALLOC, 16'd32,    16'd0);
    issue(MODE_ALLOC, 16'd1,     16'd0);
    issue(MODE_FREE,  16'd0,     16'd960);
    issue(MODE_FREE,  16'd0,     16'd0);
    issue(MODE_ALLOC, 16'd129,   16'd0);

    // pool below one block, then an empty pool
    write_pool(16'd31);
    issue(MODE_ALLOC, 16'd31,    16'd0);
    issue(MODE_ALLOC, 16'd32,    16'd0);
    write_pool(16'd0);
    issue(MODE_ALLOC, 16'd1,     16'd0);

    // random phases over several pool sizes, the extremes among them
    random_phase(16'hFFFF, 180);
    random_phase(16'd1024, 150);
    random_phase(16'd0,    20);
    random_phase(16'd31,   20);
    random_phase(16'd4000, 150);
    random_phase(16'd100,  60);
    no_idle = 1'b1;
    random_phase(16'd32768, 200);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
